/* rtl/dls_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the arctangent table for the direction to lat-long unit.
package dls_pkg;

	localparam int SQ_STEPS = 15;
	localparam int V_W      = 29;
	localparam int RES_W    = 30;
	localparam int VEC_W    = 36;
	localparam int ANG_W    = 34;
	localparam int TAB_N    = 24;

	typedef struct packed {
		logic [V_W-1:0]   v;
		logic [RES_W-1:0] res;
		logic signed [15:0] x;
		logic signed [15:0] z;
		logic signed [15:0] yc;
		logic             is_short;
	} sq_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] ang;
		logic                    hold;
	} cvec_t;

	typedef struct packed {
		cvec_t lat;
		cvec_t lon;
		logic  is_short;
	} cord_t;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			default: r = 32'h00000051;
		endcase
		return r;
	endfunction

endpackage

/* rtl/dls_sqrt_cell.sv */
`timescale 1ns / 1ps
// One digit step of the integer square root, registered.
module dls_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  dls_pkg::sq_t  d_i,
	output logic          vld_o,
	output dls_pkg::sq_t  d_o
);

	localparam logic [dls_pkg::RES_W:0] BIT =
		(dls_pkg::RES_W+1)'(1) << (2 * (dls_pkg::SQ_STEPS - 1 - STEP));

	logic                    vld_q;
	dls_pkg::sq_t            d_q;
	dls_pkg::sq_t            nx;
	logic [dls_pkg::RES_W:0] sum;

	always_comb begin
		nx  = d_i;
		sum = {1'b0, d_i.res} + BIT;
		if ({2'b00, d_i.v} >= sum) begin
			nx.v   = d_i.v - sum[dls_pkg::V_W-1:0];
			nx.res = (d_i.res >> 1) + BIT[dls_pkg::RES_W-1:0];
		end else begin
			nx.res = d_i.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= nx;
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

/* rtl/dls_cordic_cell.sv */
`timescale 1ns / 1ps
// One vectoring rotation for both angles, registered.
module dls_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_i,
	input  dls_pkg::cord_t d_i,
	output logic           vld_o,
	output dls_pkg::cord_t d_o
);

	localparam logic signed [dls_pkg::ANG_W-1:0] DA =
		dls_pkg::ANG_W'(dls_pkg::atan_turn(STEP));

	function automatic dls_pkg::cvec_t rot(input dls_pkg::cvec_t c);
		dls_pkg::cvec_t r;
		logic signed [dls_pkg::VEC_W-1:0] dx;
		logic signed [dls_pkg::VEC_W-1:0] dy;
		r  = c;
		dx = c.x >>> STEP;
		dy = c.y >>> STEP;
		if (!c.hold) begin
			if (c.y > 0) begin
				r.x   = c.x + dy;
				r.y   = c.y - dx;
				r.ang = c.ang + DA;
			end else begin
				r.x   = c.x - dy;
				r.y   = c.y + dx;
				r.ang = c.ang - DA;
			end
		end
		return r;
	endfunction

	logic           vld_q;
	dls_pkg::cord_t d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		d_q.lat      <= rot(d_i.lat);
		d_q.lon      <= rot(d_i.lon);
		d_q.is_short <= d_i.is_short;
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

/* rtl/direction_to_latlong_st_unit.sv */
`timescale 1ns / 1ps
// Top level: direction vector to latitude-longitude texture coordinates.
// One pixel is taken every cycle (busy stays low); the result strobes on done
// after passing through the two setup stages, the 15-cell square-root row,
// the CORDIC cell row and the output register.
// The receiver cannot stall; results appear in input order.
module direction_to_latlong_st_unit #(
	parameter int CORDIC_STAGES = 16,
	parameter int COORD_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	output logic               done,
	output logic [15:0]        s_coord,
	output logic [15:0]        t_coord,
	output logic               too_short
);

	localparam int CB = COORD_BITS;
	localparam int VW = dls_pkg::VEC_W;
	localparam int AW = dls_pkg::ANG_W;
	localparam logic [1:0] REG_SWAP  = 2'd0;
	localparam logic [1:0] REG_INV_S = 2'd1;
	localparam logic [1:0] REG_INV_T = 2'd2;
	localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< 31);

	// configuration
	logic swap_q, inv_s_q, inv_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q  <= 1'b0;
			inv_s_q <= 1'b0;
			inv_t_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_SWAP:  swap_q  <= pwdata[0];
				REG_INV_S: inv_s_q <= pwdata[0];
				REG_INV_T: inv_t_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SWAP:  prdata = {31'd0, swap_q};
			REG_INV_S: prdata = {31'd0, inv_s_q};
			REG_INV_T: prdata = {31'd0, inv_t_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	// stage 1: capture beat
	logic               vld_s1;
	logic signed [15:0] x_s1, y_s1, z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= dir_x;
		y_s1 <= dir_y;
		z_s1 <= dir_z;
	end

	// stage 2: squares
	logic signed [15:0] yc_c;
	logic               vld_s2;
	logic [30:0]        xx_s2, yy_s2, zz_s2;
	logic [28:0]        ycsq_s2;
	logic signed [15:0] x_s2, z_s2, yc_s2;

	always_comb begin
		if (y_s1 > 16'sd16384) begin
			yc_c = 16'sd16384;
		end else if (y_s1 < -16'sd16384) begin
			yc_c = -16'sd16384;
		end else begin
			yc_c = y_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xx_s2   <= 31'(32'(x_s1 * x_s1));
		yy_s2   <= 31'(32'(y_s1 * y_s1));
		zz_s2   <= 31'(32'(z_s1 * z_s1));
		ycsq_s2 <= 29'(32'(yc_c * yc_c));
		x_s2    <= x_s1;
		z_s2    <= z_s1;
		yc_s2   <= yc_c;
	end

	// square-root row
	logic [31:0]  ssum_c;
	logic         sq_vld [dls_pkg::SQ_STEPS+1];
	dls_pkg::sq_t sq_d   [dls_pkg::SQ_STEPS+1];

	assign ssum_c = {1'b0, xx_s2} + {1'b0, yy_s2} + {1'b0, zz_s2};

	always_comb begin
		sq_vld[0]         = vld_s2;
		sq_d[0].v         = (29'd1 << 28) - ycsq_s2;
		sq_d[0].res       = '0;
		sq_d[0].x         = x_s2;
		sq_d[0].z         = z_s2;
		sq_d[0].yc        = yc_s2;
		sq_d[0].is_short  = ssum_c < 32'd3;
	end

	for (genvar k = 0; k < dls_pkg::SQ_STEPS; k++) begin : g_sq
		dls_sqrt_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq_vld[k]),
			.d_i    (sq_d[k]),
			.vld_o  (sq_vld[k+1]),
			.d_o    (sq_d[k+1])
		);
	end

	// CORDIC setup
	dls_pkg::sq_t   sq_last;
	logic           cd_vld [CORDIC_STAGES+1];
	dls_pkg::cord_t cd_d   [CORDIC_STAGES+1];

	assign sq_last = sq_d[dls_pkg::SQ_STEPS];

	always_comb begin
		dls_pkg::cvec_t la;
		dls_pkg::cvec_t lo;
		la.x    = VW'(sq_last.yc) <<< 16;
		la.y    = VW'({1'b0, sq_last.res}) <<< 16;
		la.ang  = '0;
		la.hold = 1'b0;
		if (sq_last.res == '0) begin
			la.hold = 1'b1;
			la.ang  = (la.x < 0) ? HALF : '0;
		end else if (la.x < 0) begin
			la.ang = HALF;
			la.x   = -la.x;
			la.y   = -la.y;
		end
		lo.x    = VW'(sq_last.x) <<< 16;
		lo.y    = VW'(sq_last.z) <<< 16;
		lo.ang  = '0;
		lo.hold = 1'b0;
		if (sq_last.z == 16'sd0) begin
			lo.hold = 1'b1;
			lo.ang  = (lo.x < 0) ? HALF : '0;
		end else if (lo.x < 0) begin
			lo.ang = (lo.y >= 0) ? HALF : -HALF;
			lo.x   = -lo.x;
			lo.y   = -lo.y;
		end
		cd_vld[0]         = sq_vld[dls_pkg::SQ_STEPS];
		cd_d[0].lat       = la;
		cd_d[0].lon       = lo;
		cd_d[0].is_short  = sq_last.is_short;
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cd
		dls_cordic_cell #(.STEP(k)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (cd_vld[k]),
			.d_i    (cd_d[k]),
			.vld_o  (cd_vld[k+1]),
			.d_o    (cd_d[k+1])
		);
	end

	// output formatting
	function automatic logic [CB:0] to_coord(input logic signed [VW-1:0] v);
		logic [32:0] c;
		logic [33:0] sum;
		if (v < 0) begin
			c = '0;
		end else if (v > (VW'(64'sd1 <<< 32))) begin
			c = 33'h1_0000_0000;
		end else begin
			c = v[32:0];
		end
		sum = {1'b0, c} + (34'd1 << (31 - CB));
		return sum[32:32-CB];
	endfunction

	function automatic logic [15:0] finish(input logic [CB:0] v, input logic inv);
		logic [CB:0]      t;
		logic [CB-1:0]    sat;
		logic [CB+23:0]   wide;
		t = inv ? (((CB+1)'(1) << CB) - v) : v;
		sat  = t[CB] ? '1 : t[CB-1:0];
		wide = {sat, 24'd0};
		return wide[CB+23 -: 16];
	endfunction

	dls_pkg::cord_t    fin;
	logic signed [VW-1:0] lat_v, lon_v;
	logic [CB:0]       lat_c, lon_c, s_c, t_c;
	logic              done_q, too_short_q;
	logic [15:0]       s_coord_q, t_coord_q;

	assign fin   = cd_d[CORDIC_STAGES];
	assign lat_v = VW'(fin.lat.ang) <<< 1;
	assign lon_v = VW'(fin.lon.ang) + VW'(HALF);
	assign lat_c = to_coord(lat_v);
	assign lon_c = to_coord(lon_v);
	assign s_c   = swap_q ? lon_c : lat_c;
	assign t_c   = swap_q ? lat_c : lon_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cd_vld[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		too_short_q <= fin.is_short;
		s_coord_q   <= fin.is_short ? 16'd0 : finish(s_c, inv_s_q);
		t_coord_q   <= fin.is_short ? 16'd0 : finish(t_c, inv_t_q);
	end

	assign done      = done_q;
	assign s_coord   = s_coord_q;
	assign t_coord   = t_coord_q;
	assign too_short = too_short_q;

endmodule

/* sim/latlong_checker.sv */
`timescale 1ns / 1ps
// Checker for the lat-long unit: tracks register writes, predicts each pixel's coordinates
// and compares them with every result beat.
module latlong_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic               done,
	input  logic [15:0]        s_coord,
	input  logic [15:0]        t_coord,
	input  logic               too_short,
	output int                 fails,
	output int                 pending
);

	localparam int STAGES    = 16;
	localparam int CRD_BITS  = 16;
	localparam logic [3:0] ADDR_SWAP  = 4'd0;
	localparam logic [3:0] ADDR_INV_S = 4'd4;
	localparam logic [3:0] ADDR_INV_T = 4'd8;

	typedef struct packed {
		logic [15:0] s;
		logic [15:0] t;
		logic        short_flag;
	} uv_t;

	logic cfg_swap, cfg_inv_s, cfg_inv_t;
	uv_t  uv_q[$];

	function automatic longint int_sqrt(input longint val);
		longint r, b, v;
		r = 0;
		b = 64'd1 << 30;
		v = val;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// atan2(yv, xv) in 2^-32 turn
	function automatic longint turn_angle(input longint yv_in, input longint xv_in);
		longint yv, xv, ang, dx, dy;
		ang = 0;
		yv = yv_in;
		xv = xv_in;
		if (yv == 0) return (xv >= 0) ? 64'sd0 : (64'sd1 <<< 31);
		if (xv < 0) begin
			ang = (yv >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = xv >>> i;
			dy = yv >>> i;
			if (yv > 0) begin
				xv = xv + dy;
				yv = yv - dx;
				ang = ang + longint'(dls_pkg::atan_turn(i));
			end else begin
				xv = xv - dy;
				yv = yv + dx;
				ang = ang - longint'(dls_pkg::atan_turn(i));
			end
		end
		return ang;
	endfunction

	function automatic longint frac_round(input longint v_in);
		longint v;
		v = v_in;
		if (v < 0) v = 0;
		if (v > (64'sd1 <<< 32)) v = 64'sd1 <<< 32;
		return (v + (64'sd1 <<< (31 - CRD_BITS))) >>> (32 - CRD_BITS);
	endfunction

	function automatic logic [15:0] frac_out(input longint v_in, input logic inv);
		longint one, v;
		one = 64'sd1 <<< CRD_BITS;
		v = v_in;
		if (inv) v = one - v;
		if (v > one - 1) v = one - 1;
		return v[15:0];
	endfunction

	function automatic uv_t predict_uv(input logic signed [15:0] xi, input logic signed [15:0] yi,
			input logic signed [15:0] zi);
		uv_t r;
		longint x, y, z, yc, w, lat, lon, s, t;
		x = xi;
		y = yi;
		z = zi;
		if (x * x + y * y + z * z < 3) begin
			r.s = '0;
			r.t = '0;
			r.short_flag = 1'b1;
			return r;
		end
		yc = (y > 16384) ? 16384 : ((y < -16384) ? -16384 : y);
		w = int_sqrt((64'sd1 <<< 28) - yc * yc);
		lat = frac_round(turn_angle(w * 65536, yc * 65536) * 2);
		lon = frac_round(turn_angle(z * 65536, x * 65536) + (64'sd1 <<< 31));
		s = cfg_swap ? lon : lat;
		t = cfg_swap ? lat : lon;
		r.s = frac_out(s, cfg_inv_s);
		r.t = frac_out(t, cfg_inv_t);
		r.short_flag = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		fails++;
	endtask

	initial fails = 0;
	assign pending = uv_q.size();

	always @(posedge clk or negedge arst_n) begin
		uv_t want;
		if (!arst_n) begin
			cfg_swap <= 1'b0;
			cfg_inv_s <= 1'b0;
			cfg_inv_t <= 1'b0;
		end else begin
			if (done) begin
				if (uv_q.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = uv_q.pop_front();
					if (s_coord !== want.s) report_mismatch("s_coord", s_coord, want.s);
					if (t_coord !== want.t) report_mismatch("t_coord", t_coord, want.t);
					if (too_short !== want.short_flag)
						report_mismatch("too_short", too_short, want.short_flag);
				end
			end
			if (start && !busy) uv_q.push_back(predict_uv(dir_x, dir_y, dir_z));
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_SWAP:  cfg_swap <= pwdata[0];
					ADDR_INV_S: cfg_inv_s <= pwdata[0];
					ADDR_INV_T: cfg_inv_t <= pwdata[0];
					default: ;
				endcase
			end
		end
	end

endmodule

/* sim/direction_to_latlong_st_unit_test.sv */
`timescale 1ns / 1ps
// Testbench top for the lat-long unit: clock, reset, register writes, pixel stimulus, verdict.
module direction_to_latlong_st_unit_test;

	localparam logic [3:0] ADDR_SWAP  = 4'd0;
	localparam logic [3:0] ADDR_INV_S = 4'd4;
	localparam logic [3:0] ADDR_INV_T = 4'd8;
	localparam int DRAIN_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic               done;
	logic [15:0]        s_coord, t_coord;
	logic               too_short;
	int                 fails, pending;
	int                 pixels_sent = 0;
	int                 burst_left = 0;

	always #5 clk = ~clk;

	direction_to_latlong_st_unit dut (.*);

	latlong_checker chk (.*);

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_wait;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one beat; start stays high inside a burst, gaps fall between bursts
	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 10);
		end
		burst_left--;
		start <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic random_pixel;
		int kind;
		logic [15:0] x, y, z;
		kind = $urandom_range(0, 9);
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		if (kind < 5) begin
			x = 16'($signed($urandom_range(0, 32768)) - 16384);
			y = 16'($signed($urandom_range(0, 32768)) - 16384);
			z = 16'($signed($urandom_range(0, 32768)) - 16384);
		end else if (kind < 7) begin
			x = 16'($signed($urandom_range(0, 6)) - 3);
			y = 16'($signed($urandom_range(0, 6)) - 3);
			z = 16'($signed($urandom_range(0, 6)) - 3);
		end else if (kind == 7) begin
			case ($urandom_range(0, 2))
				0: x = 16'd0;
				1: z = 16'd0;
				default: y = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			endcase
		end
		send_pixel(x, y, z);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(16'sd0, 16'sd0, 16'sd0);
		send_pixel(16'sd1, 16'sd1, 16'sd0);
		send_pixel(16'sd1, 16'sd1, 16'sd1);
		send_pixel(-16'sd1, 16'sd0, -16'sd1);
		send_pixel(16'sd0, 16'sd16384, 16'sd0);
		send_pixel(16'sd0, -16'sd16384, 16'sd0);
		send_pixel(16'sd0, 16'sd32767, 16'sd0);
		send_pixel(16'sd0, 16'h8000, 16'sd0);
		send_pixel(-16'sd16384, 16'sd0, 16'sd0);
		send_pixel(16'sd16384, 16'sd0, 16'sd0);
		send_pixel(16'sd0, 16'sd0, 16'sd16384);
		send_pixel(16'sd0, 16'sd0, -16'sd16384);
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'sd32767, 16'sd32767, 16'sd32767);
		send_pixel(16'h8000, 16'sd5, 16'sd0);
		send_pixel(16'sd32767, 16'sd0, 16'h8000);
		send_pixel(-16'sd5000, 16'sd100, 16'sd0);
		send_pixel(16'sd0, 16'sd20000, -16'sd3);
		send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
		send_pixel(16'h5555, 16'hAAAA, 16'h5555);
		drain_wait();

		for (int mode = 0; mode < 8; mode++) begin
			reg_write(ADDR_SWAP, {$urandom} & ~32'd1 | mode[0]);
			reg_write(ADDR_INV_S, {$urandom} & ~32'd1 | mode[1]);
			reg_write(ADDR_INV_T, {$urandom} & ~32'd1 | mode[2]);
			for (int n = 0; n < 240; n++) begin
				random_pixel();
				if (mode == 3 && n == 120) drain_wait();
			end
			drain_wait();
		end

		$display("run covered %0d pixels over 8 swap/invert settings, including short vectors,",
			pixels_sent);
		$display("exact axes and out-of-range y, with random sender gaps");
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
